FILE: rtl/sam_pkg.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder package
// Shared sequencer states, result status codes and port field widths.
// ----------------------------------------------------------------------------
package sam_pkg;

    // Widths of the item and result fields.
    localparam int SYMBOL_W = 8;
    localparam int FIELD_W  = 11;
    localparam int COUNT_W  = 12;
    localparam int STATUS_W = 2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_BAD_SYMBOL = 2'd2
    } sam_status_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_START,
        S_FIRST,
        S_QCHK,
        S_W_RD,
        S_W_EV,
        S_W_Q,
        S_CL_ST,
        S_CL_LNK,
        S_COPY,
        S_RD_RD,
        S_RD_EV,
        S_TAIL,
        S_FIN,
        S_OUT
    } sam_state_t;

endpackage

FILE: rtl/suffix_automaton_builder_unit.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder
// Online suffix automaton construction, one symbol per item, with
// generalized strings.
// ----------------------------------------------------------------------------
// Each item with a symbol below ALPHABET extends the automaton by that symbol,
// unless the table is full, and every item returns one result with the
// last state, its length, suffix link, first end position, the state count
// and a status. Per-state data lives in one RAM and the dense transition rows
// in a second RAM of 2*MAX_LEN*ALPHABET entries. After reset a clearing pass
// writes that whole RAM before the first item is taken. Each suffix link
// followed and each redirected transition adds to an item's work; a clone
// also copies the row of ALPHABET transitions. Close to a full table a
// read-only walk runs first to count the states needed, then the walk runs
// again. The rate is set by the transition RAM's single read and write port.
module suffix_automaton_builder_unit #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [sam_pkg::SYMBOL_W-1:0]  symbol,
    input  logic                          start_new_string,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [sam_pkg::FIELD_W-1:0]   end_state,
    output logic [sam_pkg::FIELD_W-1:0]   end_length,
    output logic [sam_pkg::FIELD_W-1:0]   end_suffix_link,
    output logic [sam_pkg::FIELD_W-1:0]   end_first_position,
    output logic [sam_pkg::COUNT_W-1:0]   states_used,
    output logic [sam_pkg::STATUS_W-1:0]  status
);

    import sam_pkg::*;

    localparam int MAX_STATES = 2 * MAX_LEN;
    localparam int SW  = $clog2(MAX_STATES);
    localparam int CW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int IW  = $clog2(ALPHABET + 1);
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int NW  = SW + 1;
    localparam int TD  = MAX_STATES * ALPHABET;
    localparam int AW  = $clog2(TD);
    localparam int STW = LW + SW + LW;

    // Transition address of state s on symbol c.
    function automatic logic [AW-1:0] tad(input logic [SW-1:0] s, input logic [CW-1:0] c);
        tad = AW'(s) * AW'(ALPHABET) + AW'(c);
    endfunction

    sam_state_t        state_reg, state_next;
    sam_status_t       status_reg, status_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [SW-1:0]     from_reg, from_next;
    logic [SW-1:0]     p_reg, p_next;
    logic [SW-1:0]     q_reg, q_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [SW-1:0]     k_reg, k_next;
    logic [SW-1:0]     last_reg, last_next;
    logic [SW-1:0]     tail_link_reg, tail_link_next;
    logic [NW-1:0]     count_reg, count_next;
    logic [LW-1:0]     lenp_reg, lenp_next;
    logic [LW-1:0]     plen_reg, plen_next;
    logic [LW-1:0]     clen_reg, clen_next;
    logic [LW-1:0]     qlen_reg, qlen_next;
    logic [SW-1:0]     qlink_reg, qlink_next;
    logic [LW-1:0]     qfpos_reg, qfpos_next;
    logic              dry_reg, dry_next;
    logic              modeb_reg, modeb_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] o_state_reg, o_state_next;
    logic [FIELD_W-1:0] o_len_reg, o_len_next;
    logic [FIELD_W-1:0] o_link_reg, o_link_next;
    logic [FIELD_W-1:0] o_fpos_reg, o_fpos_next;
    logic [COUNT_W-1:0] o_count_reg, o_count_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;

    // Memory ports.
    logic              tr_we;
    logic [AW-1:0]     tr_waddr, tr_raddr;
    logic [SW-1:0]     tr_wdata, tr_rdata;
    logic              st_we;
    logic [SW-1:0]     st_waddr, st_raddr;
    logic [STW-1:0]    st_wdata, st_rdata;

    // Decoded state entry and shared conditions.
    logic [LW-1:0]     rd_len, rd_fpos, curlen;
    logic [SW-1:0]     rd_link;
    logic              accept, sym_ok, go_nz, full1, full2, eq_first, eq_walk;

    assign rd_len   = st_rdata[STW-1:SW+LW];
    assign rd_link  = st_rdata[SW+LW-1:LW];
    assign rd_fpos  = st_rdata[LW-1:0];
    assign curlen   = lenp_reg + LW'(1);
    assign accept   = item_valid && item_ready;
    assign sym_ok   = {1'b0, symbol} < (SYMBOL_W + 1)'(ALPHABET);
    assign go_nz    = tr_rdata != '0;
    assign full1    = ({1'b0, count_reg} + (NW + 1)'(1)) > (NW + 1)'(MAX_STATES);
    assign full2    = ({1'b0, count_reg} + (NW + 1)'(2)) > (NW + 1)'(MAX_STATES);
    assign eq_first = rd_len == curlen;
    assign eq_walk  = rd_len == (plen_reg + LW'(1));

    assign item_ready         = state_reg == S_IDLE;
    assign result_valid       = out_valid_reg;
    assign end_state          = o_state_reg;
    assign end_length         = o_len_reg;
    assign end_suffix_link    = o_link_reg;
    assign end_first_position = o_fpos_reg;
    assign states_used        = o_count_reg;
    assign status             = o_status_reg;

    sam_ram #(.WIDTH(SW), .DEPTH(TD)) u_trans_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    sam_ram #(.WIDTH(STW), .DEPTH(MAX_STATES)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:    if (clr_reg == AW'(TD - 1)) state_next = S_IDLE;
            S_IDLE:   if (accept) state_next = sym_ok ? S_START : S_FIN;
            S_START:  state_next = S_FIRST;
            S_FIRST:
            begin
                if (go_nz)
                    state_next = S_QCHK;
                else
                    state_next = S_W_RD;
            end
            S_QCHK:   state_next = (eq_first || full1) ? S_FIN : S_CL_ST;
            S_W_RD:   state_next = S_W_EV;
            S_W_EV:
            begin
                if (go_nz)
                    state_next = S_W_Q;
                else if (p_reg != '0)
                    state_next = S_W_RD;
                else if (dry_reg)
                    state_next = full1 ? S_FIN : S_W_RD;
                else
                    state_next = S_TAIL;
            end
            S_W_Q:
            begin
                if (dry_reg)
                    state_next = (eq_walk ? full1 : full2) ? S_FIN : S_W_RD;
                else
                    state_next = eq_walk ? S_TAIL : S_CL_ST;
            end
            S_CL_ST:  state_next = S_CL_LNK;
            S_CL_LNK: state_next = S_COPY;
            S_COPY:   if (i_reg == IW'(ALPHABET)) state_next = S_RD_RD;
            S_RD_RD:  state_next = S_RD_EV;
            S_RD_EV:
            begin
                if (tr_rdata == q_reg && p_reg != '0)
                    state_next = S_RD_RD;
                else
                    state_next = S_TAIL;
            end
            S_TAIL:   state_next = S_FIN;
            S_FIN:    state_next = S_OUT;
            S_OUT:    if (!out_valid_reg || result_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        status_next    = status_reg;
        c_next         = c_reg;
        from_next      = from_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        tail_link_next = tail_link_reg;
        count_next     = count_reg;
        lenp_next      = lenp_reg;
        plen_next      = plen_reg;
        clen_next      = clen_reg;
        qlen_next      = qlen_reg;
        qlink_next     = qlink_reg;
        qfpos_next     = qfpos_reg;
        dry_next       = dry_reg;
        modeb_next     = modeb_reg;
        i_next         = i_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !result_ready;
        o_state_next   = o_state_reg;
        o_len_next     = o_len_reg;
        o_link_next    = o_link_reg;
        o_fpos_next    = o_fpos_reg;
        o_count_next   = o_count_reg;
        o_status_next  = o_status_reg;
        case (state_reg)
            S_CLR:    clr_next = clr_reg + AW'(1);
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = sym_ok ? ST_OK : ST_BAD_SYMBOL;
                    c_next      = CW'(symbol);
                    from_next   = start_new_string ? '0 : last_reg;
                end
            end
            S_FIRST:
            begin
                lenp_next = rd_len;
                q_next    = tr_rdata;
                p_next    = from_reg;
                plen_next = rd_len;
                if (!go_nz)
                begin
                    modeb_next = 1'b1;
                    dry_next   = full2;
                    if (!full2)
                    begin
                        cur_next   = count_reg[SW-1:0];
                        count_next = count_reg + NW'(1);
                    end
                end
            end
            S_QCHK:
            begin
                modeb_next = 1'b0;
                if (eq_first)
                    last_next = q_reg;
                else if (full1)
                    status_next = ST_TABLE_FULL;
                else
                begin
                    k_next     = count_reg[SW-1:0];
                    count_next = count_reg + NW'(1);
                    clen_next  = curlen;
                    qlen_next  = rd_len;
                    qlink_next = rd_link;
                    qfpos_next = rd_fpos;
                end
            end
            S_W_EV:
            begin
                if (go_nz)
                begin
                    q_next    = tr_rdata;
                    plen_next = rd_len;
                end
                else if (p_reg != '0)
                    p_next = rd_link;
                else if (dry_reg)
                begin
                    if (full1)
                        status_next = ST_TABLE_FULL;
                    else
                    begin
                        dry_next   = 1'b0;
                        p_next     = from_reg;
                        cur_next   = count_reg[SW-1:0];
                        count_next = count_reg + NW'(1);
                    end
                end
                else
                    tail_link_next = '0;
            end
            S_W_Q:
            begin
                if (dry_reg)
                begin
                    if (eq_walk ? full1 : full2)
                        status_next = ST_TABLE_FULL;
                    else
                    begin
                        dry_next   = 1'b0;
                        p_next     = from_reg;
                        cur_next   = count_reg[SW-1:0];
                        count_next = count_reg + NW'(1);
                    end
                end
                else if (eq_walk)
                    tail_link_next = q_reg;
                else
                begin
                    k_next         = count_reg[SW-1:0];
                    tail_link_next = count_reg[SW-1:0];
                    count_next     = count_reg + NW'(1);
                    clen_next      = plen_reg + LW'(1);
                    qlen_next      = rd_len;
                    qlink_next     = rd_link;
                    qfpos_next     = rd_fpos;
                end
            end
            S_CL_LNK: i_next = '0;
            S_COPY:   i_next = i_reg + IW'(1);
            S_RD_EV:  p_next = rd_link;
            S_TAIL:   last_next = modeb_reg ? cur_reg : k_reg;
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    o_state_next   = FIELD_W'(last_reg);
                    o_len_next     = FIELD_W'(rd_len);
                    o_link_next    = (last_reg == '0) ? '0 : FIELD_W'(rd_link);
                    o_fpos_next    = FIELD_W'(rd_fpos);
                    o_count_next   = COUNT_W'(count_reg);
                    o_status_next  = status_reg;
                end
            end
            default:  ;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        tr_we    = 1'b0;
        tr_waddr = tad(p_reg, c_reg);
        tr_wdata = cur_reg;
        tr_raddr = tad(p_reg, c_reg);
        st_we    = 1'b0;
        st_waddr = k_reg;
        st_wdata = {clen_reg, qlink_reg, qfpos_reg};
        st_raddr = last_reg;
        case (state_reg)
            S_CLR:
            begin
                tr_we    = 1'b1;
                tr_waddr = clr_reg;
                tr_wdata = '0;
                st_we    = clr_reg == '0;
                st_waddr = '0;
                st_wdata = '0;
            end
            S_START:
            begin
                tr_raddr = tad(from_reg, c_reg);
                st_raddr = from_reg;
            end
            S_FIRST:  st_raddr = tr_rdata;
            S_W_RD:   st_raddr = p_reg;
            S_W_EV:
            begin
                st_raddr = tr_rdata;
                tr_we    = !go_nz && !dry_reg;
            end
            S_CL_ST:  st_we = 1'b1;
            S_CL_LNK:
            begin
                st_we    = 1'b1;
                st_waddr = q_reg;
                st_wdata = {qlen_reg, k_reg, qfpos_reg};
            end
            S_COPY:
            begin
                tr_raddr = tad(q_reg, CW'(i_reg));
                tr_we    = i_reg != '0;
                tr_waddr = tad(k_reg, CW'(i_reg - IW'(1)));
                tr_wdata = tr_rdata;
            end
            S_RD_RD:  st_raddr = p_reg;
            S_RD_EV:
            begin
                tr_we    = tr_rdata == q_reg;
                tr_wdata = k_reg;
            end
            S_TAIL:
            begin
                st_we    = modeb_reg;
                st_waddr = cur_reg;
                st_wdata = {curlen, tail_link_reg, curlen};
            end
            default:  ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            count_reg     <= NW'(1);
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        c_reg         <= c_next;
        from_reg      <= from_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        tail_link_reg <= tail_link_next;
        lenp_reg      <= lenp_next;
        plen_reg      <= plen_next;
        clen_reg      <= clen_next;
        qlen_reg      <= qlen_next;
        qlink_reg     <= qlink_next;
        qfpos_reg     <= qfpos_next;
        dry_reg       <= dry_next;
        modeb_reg     <= modeb_next;
        i_reg         <= i_next;
        o_state_reg   <= o_state_next;
        o_len_reg     <= o_len_next;
        o_link_reg    <= o_link_next;
        o_fpos_reg    <= o_fpos_next;
        o_count_reg   <= o_count_next;
        o_status_reg  <= o_status_next;
    end

endmodule

FILE: rtl/sam_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a read of the entry written in the same cycle returns old data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
